@@ rtl/srp_pkg.sv @@
package srp_pkg;

  // Protocol byte values
  localparam logic [7:0] SocksVersion = 8'h05;
  localparam logic [7:0] RepSucceeded = 8'h00;
  localparam logic [7:0] AtypIpv4     = 8'h01;
  localparam logic [7:0] AtypDomain   = 8'h03;
  localparam logic [7:0] AtypIpv6     = 8'h04;

  // Address lengths and reply framing
  localparam logic [8:0] AlenIpv4     = 9'd4;
  localparam logic [8:0] AlenIpv6     = 9'd16;
  localparam logic [8:0] FrameBytes   = 9'd6;   // 4 header bytes + 2 port bytes
  localparam logic [8:0] IdxAddrFirst = 9'd4;
  localparam logic [8:0] IdxAddrEnd   = 9'd8;
  localparam logic [8:0] IdxVersion   = 9'd0;
  localparam logic [8:0] IdxReply     = 9'd1;
  localparam logic [8:0] IdxAtyp      = 9'd3;
  localparam logic [8:0] IdxMinDone   = 9'd5;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_REPLY = 2'd1,
    STATUS_BAD_ATYP = 2'd2,
    STATUS_LINK_ERR = 2'd3
  } status_e;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic        is_ipv4;
    logic [31:0] addr;
    logic [15:0] port;
  } result_t;

endpackage

@@ rtl/srp_if.sv @@
interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_error;

  modport source (output valid, output rx_byte, output link_error, input ready);
  modport sink (input valid, input rx_byte, input link_error, output ready);
endinterface

interface srp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reply_status;
  logic        is_ipv4;
  logic [31:0] bound_addr;
  logic [15:0] bound_port;

  modport source (
    output valid, output reply_status, output is_ipv4, output bound_addr,
    output bound_port, input ready
  );
  modport sink (
    input valid, input reply_status, input is_ipv4, input bound_addr,
    input bound_port, output ready
  );
endinterface

@@ rtl/srp_parse.sv @@
module srp_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              link_error_i,
  output srp_pkg::result_t  result_o
);

  logic [8:0]  byte_index_q, byte_index_d;
  logic [8:0]  addr_len_q, addr_len_d;
  logic [7:0]  addr_type_q, addr_type_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  reply_code_q, reply_code_d;
  logic [31:0] addr_shift_q, addr_shift_d;
  logic [15:0] port_shift_q, port_shift_d;

  logic [8:0]  alen;
  logic [8:0]  total;
  logic [8:0]  idx_next;
  logic        bad_atyp;
  logic        reply_ok;
  srp_pkg::result_t res;

  always_comb begin
    byte_index_d = byte_index_q;
    addr_len_d   = addr_len_q;
    addr_type_d  = addr_type_q;
    version_d    = version_q;
    reply_code_d = reply_code_q;
    addr_shift_d = addr_shift_q;
    port_shift_d = port_shift_q;
    res          = '0;
    res.status   = srp_pkg::STATUS_OK;
    bad_atyp     = 1'b0;
    alen         = addr_len_q;

    // Address length is set at the first address byte: from the address type, or for a domain from that byte plus one
    if (byte_index_q == srp_pkg::IdxAddrFirst) begin
      case (addr_type_q)
        srp_pkg::AtypIpv4:   alen = srp_pkg::AlenIpv4;
        srp_pkg::AtypDomain: alen = {1'b0, rx_byte_i} + 9'd1;
        srp_pkg::AtypIpv6:   alen = srp_pkg::AlenIpv6;
        default:             bad_atyp = 1'b1;
      endcase
    end
    total    = srp_pkg::FrameBytes + alen;
    idx_next = byte_index_q + 9'd1;
    reply_ok = (version_q == srp_pkg::SocksVersion) &&
               (reply_code_q == srp_pkg::RepSucceeded);

    if (fire_i) begin
      if (link_error_i) begin
        byte_index_d = '0;
        addr_len_d   = '0;
        addr_type_d  = '0;
        version_d    = '0;
        reply_code_d = '0;
        addr_shift_d = '0;
        port_shift_d = '0;
        res.valid    = 1'b1;
        res.status   = srp_pkg::STATUS_LINK_ERR;
      end else if (bad_atyp) begin
        byte_index_d = '0;
        addr_len_d   = '0;
        addr_type_d  = '0;
        version_d    = '0;
        reply_code_d = '0;
        addr_shift_d = '0;
        port_shift_d = '0;
        res.valid    = 1'b1;
        res.status   = srp_pkg::STATUS_BAD_ATYP;
      end else begin
        if (byte_index_q == srp_pkg::IdxVersion) version_d = rx_byte_i;
        if (byte_index_q == srp_pkg::IdxReply) reply_code_d = rx_byte_i;
        if (byte_index_q == srp_pkg::IdxAtyp) addr_type_d = rx_byte_i;
        addr_len_d = alen;
        if (byte_index_q >= srp_pkg::IdxAddrFirst && byte_index_q < srp_pkg::IdxAddrEnd) begin
          addr_shift_d = {addr_shift_q[23:0], rx_byte_i};
        end
        if (byte_index_q >= srp_pkg::IdxAddrFirst &&
            ({1'b0, byte_index_q} + 10'd2) >= {1'b0, total}) begin
          port_shift_d = {port_shift_q[7:0], rx_byte_i};
        end
        byte_index_d = idx_next;

        if (idx_next >= srp_pkg::IdxMinDone && idx_next == total) begin
          res.valid = 1'b1;
          if (!reply_ok) begin
            res.status = srp_pkg::STATUS_BAD_REPLY;
          end else if (addr_type_q == srp_pkg::AtypIpv4) begin
            res.is_ipv4 = 1'b1;
            res.addr    = addr_shift_d;
            res.port    = port_shift_d;
          end
          byte_index_d = '0;
          addr_len_d   = '0;
          addr_type_d  = '0;
          version_d    = '0;
          reply_code_d = '0;
          addr_shift_d = '0;
          port_shift_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_index_q <= '0;
      addr_len_q   <= '0;
      addr_type_q  <= '0;
      version_q    <= '0;
      reply_code_q <= '0;
      addr_shift_q <= '0;
      port_shift_q <= '0;
    end else begin
      byte_index_q <= byte_index_d;
      addr_len_q   <= addr_len_d;
      addr_type_q  <= addr_type_d;
      version_q    <= version_d;
      reply_code_q <= reply_code_d;
      addr_shift_q <= addr_shift_d;
      port_shift_q <= port_shift_d;
    end
  end

  assign result_o = res;

endmodule

@@ rtl/socks5_reply_parser.sv @@
// SOCKS5 reply parser.
// rx_i carries the server reply one byte per transaction (rx_byte), with a
// link_error flag that aborts the reply in progress; rsp_o carries one
// transaction per finished or aborted reply: reply_status, is_ipv4 and,
// for an IPv4 success, the bound address and port.
// Throughput: one byte per cycle while rsp_o is not stalled. Each byte is
// captured in an input register, parsed by the header/address logic once
// the output slot is free or being taken; any result lands in the output register.
// A result reaches rsp_o through the input register and then the output
// register after the transaction on rx_i that completes (or aborts) the reply.
// Reset clears the byte counter, all captured header fields and both
// valid flags; the first byte after reset starts a new reply.
// When the receiver stalls rsp_o, the pending result and the parse stage
// hold; rx_i takes one more byte into the input register if it is empty,
// then drops ready until the output register frees up. No byte is lost.
module socks5_reply_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  srp_in_if.sink         rx_i,
  srp_out_if.source      rsp_o
);

  // Input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_err_q;

  // Output register
  logic             out_valid_q, out_valid_d;
  srp_pkg::result_t out_res_q;
  srp_pkg::result_t res;

  logic advance;
  logic in_take;

  // Advance the parse stage when a byte is held and the output slot is free or being taken.
  assign advance = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign rx_i.ready = !in_valid_q || advance;
  assign in_take = rx_i.valid && rx_i.ready;

  srp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (advance),
    .rx_byte_i    (in_byte_q),
    .link_error_i (in_err_q),
    .result_o     (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = res.valid;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture payloads; hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= rx_i.rx_byte;
      in_err_q  <= rx_i.link_error;
    end
    if (advance && res.valid) begin
      out_res_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.reply_status = out_res_q.status;
  assign rsp_o.is_ipv4      = out_res_q.is_ipv4;
  assign rsp_o.bound_addr   = out_res_q.addr;
  assign rsp_o.bound_port   = out_res_q.port;

endmodule

@@ rtl/srp_checker.sv @@
module srp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  reply_status_i,
  input logic        is_ipv4_i,
  input logic [31:0] bound_addr_i,
  input logic [15:0] bound_port_i
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(reply_status_i) &&
      $stable(is_ipv4_i) && $stable(bound_addr_i) && $stable(bound_port_i))
    else $error("stalled result changed");

  // Only a success can carry an IPv4 address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && is_ipv4_i |-> reply_status_i == srp_pkg::STATUS_OK)
    else $error("is_ipv4 set on a failed reply");

  // Address and port are zero unless the result is IPv4.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !is_ipv4_i |-> bound_addr_i == 32'd0 && bound_port_i == 16'd0)
    else $error("address fields set without IPv4");

  // Reset drops the result.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind socks5_reply_parser srp_checker u_srp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .reply_status_i (rsp_o.reply_status),
  .is_ipv4_i      (rsp_o.is_ipv4),
  .bound_addr_i   (rsp_o.bound_addr),
  .bound_port_i   (rsp_o.bound_port)
);
